// ===== rtl/core/qte_pkg.sv =====
// Shared constants, widths and the CORDIC angle table of the quaternion to Euler unit.
package qte_pkg;

  // Field widths
  localparam int COMP_W   = 16;  // quaternion component, signed Q14
  localparam int STAT_W   = 8;
  localparam int ACC_W    = 2;
  localparam int NORM_W   = 16;  // configured norm bounds
  localparam int ANGLE_W  = 16;  // roll and yaw, signed Q7
  localparam int PITCH_W  = 15;  // pitch, signed Q7
  localparam int NQ       = 4;   // components per sample

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM_MIN = 1'b0,
    REG_NORM_MAX = 1'b1
  } reg_idx_t;

  localparam logic [NORM_W-1:0] NORM_MIN_RST = 16'd13107;
  localparam logic [NORM_W-1:0] NORM_MAX_RST = 16'd19661;

  // Square root pipeline: one root bit per stage
  localparam int SQRT_STEPS = 29;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int NRM_W      = 17;  // norm of a sample, at most 65536

  // Normalizing divider: one quotient bit per stage
  localparam int DIV_STEPS = 15;
  localparam int QUO_W     = DIV_STEPS;
  localparam int DIV_W     = 32;
  localparam int DVS_W     = NRM_W + 1;
  localparam int NSH       = 15;  // component * 16384 * 2

  // Angle arguments, Q28
  localparam int ARG_W = 33;
  localparam int Q28   = 28;
  localparam logic signed [ARG_W-1:0] ONE_Q28 = ARG_W'(1) << Q28;

  // CORDIC core
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int TABLE_LEN    = 24;
  localparam int CW           = ARG_W + 1;
  localparam int ANG_W        = 26;  // Q16 degrees accumulator
  localparam int RND_SH       = 9;   // Q16 to Q7
  localparam int RM_W         = ANG_W - RND_SH;
  localparam int ANG_HALF     = 180 * 65536;
  localparam int ANG_LIM      = 23040;
  localparam int PITCH_LIM    = 11520;

  // atan(2^-i) in degrees, Q16
  localparam int ATAN_TAB [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Pipeline depth from input register to output register
  localparam int PIPE_LEN = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1 + 4 + SQRT_STEPS
                            + CORDIC_LAT + 1;

endpackage

// ===== rtl/core/qte_isqrt.sv =====
// Pipelined floor square root, one root bit resolved per register stage.
module qte_isqrt
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] rem_r   [SQRT_STEPS];
  logic [RAD_W-1:0] rt_r    [SQRT_STEPS];
  logic [RAD_W-1:0] rem_in  [SQRT_STEPS];
  logic [RAD_W-1:0] rt_in   [SQRT_STEPS];
  logic [RAD_W-1:0] trial   [SQRT_STEPS];
  logic [RAD_W-1:0] bitv    [SQRT_STEPS];
  logic [RAD_W-1:0] rem_nxt [SQRT_STEPS];
  logic [RAD_W-1:0] rt_nxt  [SQRT_STEPS];

  // Chain each stage to the one before it
  assign rem_in[0] = rad;
  assign rt_in[0]  = '0;
  for (genvar j = 1; j < SQRT_STEPS; j++) begin : g_link
    assign rem_in[j] = rem_r[j-1];
    assign rt_in[j]  = rt_r[j-1];
  end

  // Try one root bit per stage
  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv[j]  = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      trial[j] = rt_in[j] + bitv[j];
      if (rem_in[j] >= trial[j]) begin
        rem_nxt[j] = rem_in[j] - trial[j];
        rt_nxt[j]  = (rt_in[j] >> 1) + bitv[j];
      end else begin
        rem_nxt[j] = rem_in[j];
        rt_nxt[j]  = rt_in[j] >> 1;
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        rt_r[j]  <= rt_nxt[j];
      end
    end
  end

  assign root = rt_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/qte_cordic.sv =====
// Pipelined vectoring CORDIC: atan2 of Q28 arguments to clamped Q7 degrees.
module qte_cordic
  import qte_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ARG_W-1:0]   y_in,
  input  logic signed [ARG_W-1:0]   x_in,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [CW-1:0]    x_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0]    y_r   [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ang_r [CORDIC_STEPS+1];
  logic                    zero_r [CORDIC_STEPS+1];

  logic signed [CW-1:0]    x_nxt   [CORDIC_STEPS];
  logic signed [CW-1:0]    y_nxt   [CORDIC_STEPS];
  logic signed [ANG_W-1:0] ang_nxt [CORDIC_STEPS];
  logic signed [CW-1:0]    xs      [CORDIC_STEPS];
  logic signed [CW-1:0]    ys      [CORDIC_STEPS];

  logic signed [CW-1:0]      xe, ye, x_pre, y_pre;
  logic signed [ANG_W-1:0]   ang_pre;
  logic                      zero_pre;
  logic signed [ANG_W-1:0]   ang_fin, mag;
  logic [ANG_W-1:0]          rnd;
  logic [RM_W-1:0]           rm, lim;
  logic signed [ANGLE_W-1:0] lim16, angle_nxt, angle_r;

  // Fold the left half plane onto the right
  always_comb begin
    xe       = {{(CW-ARG_W){x_in[ARG_W-1]}}, x_in};
    ye       = {{(CW-ARG_W){y_in[ARG_W-1]}}, y_in};
    zero_pre = (x_in == '0) && (y_in == '0);
    if (xe < 0) begin
      x_pre   = -xe;
      y_pre   = -ye;
      ang_pre = (ye >= 0) ? ANG_W'(ANG_HALF) : -ANG_W'(ANG_HALF);
    end else begin
      x_pre   = xe;
      y_pre   = ye;
      ang_pre = '0;
    end
  end

  // Rotate toward the x axis, one micro-rotation per stage
  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs[i] = x_r[i] >>> i;
      ys[i] = y_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_nxt[i]   = x_r[i] + ys[i];
        y_nxt[i]   = y_r[i] - xs[i];
        ang_nxt[i] = ang_r[i] + ANG_W'(ATAN_TAB[i]);
      end else begin
        x_nxt[i]   = x_r[i] - ys[i];
        y_nxt[i]   = y_r[i] + xs[i];
        ang_nxt[i] = ang_r[i] - ANG_W'(ATAN_TAB[i]);
      end
    end
  end

  // Round Q16 to Q7 half away from zero, then clamp
  always_comb begin
    ang_fin = ang_r[CORDIC_STEPS];
    mag     = (ang_fin < 0) ? -ang_fin : ang_fin;
    rnd     = (ANG_W'(mag) + ANG_W'(256)) >> RND_SH;
    rm      = rnd[RM_W-1:0];
    lim     = (rm > RM_W'(ANG_LIM)) ? RM_W'(ANG_LIM) : rm;
    lim16   = ANGLE_W'(lim);
    if (zero_r[CORDIC_STEPS]) begin
      angle_nxt = '0;
    end else if (ang_fin < 0) begin
      angle_nxt = -lim16;
    end else begin
      angle_nxt = lim16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_pre;
      y_r[0]    <= y_pre;
      ang_r[0]  <= ang_pre;
      zero_r[0] <= zero_pre;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i+1]    <= x_nxt[i];
        y_r[i+1]    <= y_nxt[i];
        ang_r[i+1]  <= ang_nxt[i];
        zero_r[i+1] <= zero_r[i];
      end
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

// ===== rtl/core/quaternion_to_euler_gated_unit.sv =====
// Top level: norm-gated quaternion normalizer and ZYX Euler angle converter.
//
//  channel | direction | handshake           | payload
//  in_     | to unit   | in_valid / in_stall | quat_w, quat_x, quat_y, quat_z, status_bits
//  out_    | from unit | out_valid/out_stall | sample_ok, norm_w..z, roll, pitch, yaw, accuracy
//  cfg_    | to unit   | cfg_valid/cfg_ready | cfg_index, cfg_value (norm_min, norm_max)
//
// One item enters per cycle unless in_stall is high; each result leaves through the PIPE_LEN registers.
// The depth is set by two 29-stage square root pipelines, the 15-stage divider
// and the 18-stage CORDIC cores. Reset clears the valid bits and loads the norm window.
// A stalled output freezes the whole pipeline, so in_stall follows
// out_valid and out_stall in the same cycle; bubbles travel with the items.
module quaternion_to_euler_gated_unit
  import qte_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COMP_W-1:0]  in_quat_w,
  input  logic signed [COMP_W-1:0]  in_quat_x,
  input  logic signed [COMP_W-1:0]  in_quat_y,
  input  logic signed [COMP_W-1:0]  in_quat_z,
  input  logic [STAT_W-1:0]         in_status_bits,
  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_sample_ok,
  output logic signed [COMP_W-1:0]  out_norm_w,
  output logic signed [COMP_W-1:0]  out_norm_x,
  output logic signed [COMP_W-1:0]  out_norm_y,
  output logic signed [COMP_W-1:0]  out_norm_z,
  output logic signed [ANGLE_W-1:0] out_roll_deg,
  output logic signed [PITCH_W-1:0] out_pitch_deg,
  output logic signed [ANGLE_W-1:0] out_yaw_deg,
  output logic [ACC_W-1:0]          out_accuracy,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [NORM_W-1:0]         cfg_value
);

  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic [ACC_W-1:0]         acc;
  } samp_t;

  typedef struct packed {
    logic [NQ-1:0]    neg;
    logic             ok;
    logic [ACC_W-1:0] acc;
  } dside_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic                     ok;
    logic [ACC_W-1:0]         acc;
  } nq_t;

  typedef struct packed {
    nq_t                     nq;
    logic signed [ARG_W-1:0] ry;
    logic signed [ARG_W-1:0] rx;
    logic signed [ARG_W-1:0] yy;
    logic signed [ARG_W-1:0] yx;
    logic signed [ARG_W-1:0] sp;
    logic                    pole_pos;
    logic                    pole_neg;
  } trig_t;

  typedef struct packed {
    nq_t  nq;
    logic pole_pos;
    logic pole_neg;
  } fin_t;

  function automatic logic signed [ARG_W-1:0] ext32(input logic signed [31:0] v);
    return {{(ARG_W-32){v[31]}}, v};
  endfunction

  logic adv;
  logic vld_r [PIPE_LEN];
  logic [NORM_W-1:0] norm_min_r, norm_max_r;

  // Pipeline advances unless a finished item is held at the output
  assign adv       = !vld_r[PIPE_LEN-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_LEN-1];
  assign cfg_ready = 1'b1;

  // Valid bits and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LEN; k++) begin
        vld_r[k] <= 1'b0;
      end
      norm_min_r <= NORM_MIN_RST;
      norm_max_r <= NORM_MAX_RST;
    end else begin
      if (adv) begin
        vld_r[0] <= in_valid;
        for (int k = 1; k < PIPE_LEN; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_NORM_MIN: norm_min_r <= cfg_value;
          REG_NORM_MAX: norm_max_r <= cfg_value;
          default:      norm_min_r <= norm_min_r;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Squares, sum of squares and the norm
  // ---------------------------------------------------------------------------
  logic signed [31:0] sq_full [NQ];
  logic [30:0]        sq_r    [NQ];
  samp_t              s_in, s1_r, s2_r;
  logic [32:0]        sum_r;
  logic [ROOT_W-1:0]  norm_root;
  samp_t              sda_r [SQRT_STEPS];

  always_comb begin
    s_in.w   = in_quat_w;
    s_in.x   = in_quat_x;
    s_in.y   = in_quat_y;
    s_in.z   = in_quat_z;
    s_in.acc = in_status_bits[ACC_W-1:0];
    sq_full[0] = in_quat_w * in_quat_w;
    sq_full[1] = in_quat_x * in_quat_x;
    sq_full[2] = in_quat_y * in_quat_y;
    sq_full[3] = in_quat_z * in_quat_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NQ; l++) begin
        sq_r[l] <= sq_full[l][30:0];
      end
      s1_r  <= s_in;
      sum_r <= 33'(sq_r[0]) + 33'(sq_r[1]) + 33'(sq_r[2]) + 33'(sq_r[3]);
      s2_r  <= s1_r;
      sda_r[0] <= s2_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sda_r[k] <= sda_r[k-1];
      end
    end
  end

  qte_isqrt u_norm_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (RAD_W'(sum_r)),
    .root (norm_root)
  );

  // ---------------------------------------------------------------------------
  // Window check and normalizing divider, one quotient bit per stage
  // ---------------------------------------------------------------------------
  samp_t               sa;
  logic [NRM_W-1:0]    nrm;
  logic signed [COMP_W-1:0] cq [NQ];
  logic [COMP_W-1:0]   cmag [NQ];
  logic [DIV_W-1:0]    rem0 [NQ];
  dside_t              dside0;

  logic [DIV_W-1:0]    dv_rem_r   [DIV_STEPS+1][NQ];
  logic [QUO_W-1:0]    dv_quo_r   [DIV_STEPS+1][NQ];
  logic [DVS_W-1:0]    dv_d_r     [DIV_STEPS+1];
  dside_t              dv_side_r  [DIV_STEPS+1];
  logic [DIV_W-1:0]    dv_sub     [DIV_STEPS];
  logic [DIV_W-1:0]    dv_rem_nxt [DIV_STEPS][NQ];
  logic [QUO_W-1:0]    dv_quo_nxt [DIV_STEPS][NQ];

  always_comb begin
    sa    = sda_r[SQRT_STEPS-1];
    nrm   = norm_root[NRM_W-1:0];
    cq[0] = sa.w;
    cq[1] = sa.x;
    cq[2] = sa.y;
    cq[3] = sa.z;
    dside0.ok  = (nrm != '0) && (nrm >= NRM_W'(norm_min_r)) && (nrm <= NRM_W'(norm_max_r));
    dside0.acc = sa.acc;
    for (int l = 0; l < NQ; l++) begin
      cmag[l] = cq[l][COMP_W-1] ? COMP_W'(-cq[l]) : COMP_W'(cq[l]);
      rem0[l] = (DIV_W'(cmag[l]) << NSH) + DIV_W'(nrm);
      dside0.neg[l] = cq[l][COMP_W-1];
    end
  end

  // Restoring division by twice the norm
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_sub[k] = DIV_W'(dv_d_r[k]) << (DIV_STEPS - 1 - k);
      for (int l = 0; l < NQ; l++) begin
        if (dv_rem_r[k][l] >= dv_sub[k]) begin
          dv_rem_nxt[k][l] = dv_rem_r[k][l] - dv_sub[k];
          dv_quo_nxt[k][l] = {dv_quo_r[k][l][QUO_W-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k][l] = dv_rem_r[k][l];
          dv_quo_nxt[k][l] = {dv_quo_r[k][l][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_d_r[0]    <= {nrm, 1'b0};
      dv_side_r[0] <= dside0;
      for (int l = 0; l < NQ; l++) begin
        dv_rem_r[0][l] <= rem0[l];
        dv_quo_r[0][l] <= '0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_d_r[k+1]    <= dv_d_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
        for (int l = 0; l < NQ; l++) begin
          dv_rem_r[k+1][l] <= dv_rem_nxt[k][l];
          dv_quo_r[k+1][l] <= dv_quo_nxt[k][l];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Signed components, products and the angle arguments
  // ---------------------------------------------------------------------------
  dside_t                   dq;
  logic signed [COMP_W-1:0] nsv [NQ];
  nq_t                      nq_nxt, nq48_r, nq49_r;
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  trig_t                    t50_nxt, t50_r, t51_nxt, t51_r, t52_r;
  logic signed [ARG_W-1:0]  spa;
  logic [Q28-1:0]           s_abs;
  logic [2*Q28-1:0]         ssq_r;
  logic [RAD_W-1:0]         rad_r;

  always_comb begin
    dq = dv_side_r[DIV_STEPS];
    for (int l = 0; l < NQ; l++) begin
      nsv[l] = dq.neg[l] ? -COMP_W'(dv_quo_r[DIV_STEPS][l])
                         : COMP_W'(dv_quo_r[DIV_STEPS][l]);
    end
    nq_nxt.w   = nsv[0];
    nq_nxt.x   = nsv[1];
    nq_nxt.y   = nsv[2];
    nq_nxt.z   = nsv[3];
    nq_nxt.ok  = dq.ok;
    nq_nxt.acc = dq.acc;
  end

  // Form the doubled sums for roll, yaw and pitch
  always_comb begin
    t50_nxt.nq       = nq49_r;
    t50_nxt.ry       = (ext32(p_wx_r) + ext32(p_yz_r)) <<< 1;
    t50_nxt.rx       = ONE_Q28 - ((ext32(p_xx_r) + ext32(p_yy_r)) <<< 1);
    t50_nxt.yy       = (ext32(p_wz_r) + ext32(p_xy_r)) <<< 1;
    t50_nxt.yx       = ONE_Q28 - ((ext32(p_yy_r) + ext32(p_zz_r)) <<< 1);
    t50_nxt.sp       = (ext32(p_wy_r) - ext32(p_zx_r)) <<< 1;
    t50_nxt.pole_pos = 1'b0;
    t50_nxt.pole_neg = 1'b0;
  end

  // Flag the poles and take the magnitude of the pitch sine
  always_comb begin
    t51_nxt          = t50_r;
    t51_nxt.pole_pos = t50_r.sp >= ONE_Q28;
    t51_nxt.pole_neg = t50_r.sp <= -ONE_Q28;
    spa              = t50_r.sp[ARG_W-1] ? -t50_r.sp : t50_r.sp;
    s_abs            = spa[Q28-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nq48_r <= nq_nxt;
      p_wx_r <= nq48_r.w * nq48_r.x;
      p_yz_r <= nq48_r.y * nq48_r.z;
      p_xx_r <= nq48_r.x * nq48_r.x;
      p_yy_r <= nq48_r.y * nq48_r.y;
      p_wz_r <= nq48_r.w * nq48_r.z;
      p_xy_r <= nq48_r.x * nq48_r.y;
      p_zz_r <= nq48_r.z * nq48_r.z;
      p_wy_r <= nq48_r.w * nq48_r.y;
      p_zx_r <= nq48_r.z * nq48_r.x;
      nq49_r <= nq48_r;
      t50_r  <= t50_nxt;
      t51_r  <= t51_nxt;
      ssq_r  <= s_abs * s_abs;
      t52_r  <= t51_r;
      rad_r  <= (RAD_W'(1) << (2 * Q28)) - RAD_W'(ssq_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Pitch cosine, then three CORDIC cores side by side
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0]         cos_root;
  trig_t                     sdb_r [SQRT_STEPS];
  trig_t                     tb;
  fin_t                      fin_nxt;
  fin_t                      sdc_r [CORDIC_LAT];
  logic signed [ANGLE_W-1:0] roll_ang, yaw_ang, pitch_ang;

  qte_isqrt u_cos_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad_r),
    .root (cos_root)
  );

  always_comb begin
    tb               = sdb_r[SQRT_STEPS-1];
    fin_nxt.nq       = tb.nq;
    fin_nxt.pole_pos = tb.pole_pos;
    fin_nxt.pole_neg = tb.pole_neg;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdb_r[0] <= t52_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sdb_r[k] <= sdb_r[k-1];
      end
      sdc_r[0] <= fin_nxt;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        sdc_r[k] <= sdc_r[k-1];
      end
    end
  end

  qte_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .y_in  (tb.ry),
    .x_in  (tb.rx),
    .angle (roll_ang)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (adv),
    .y_in  (tb.yy),
    .x_in  (tb.yx),
    .angle (yaw_ang)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .y_in  (tb.sp),
    .x_in  (ARG_W'(cos_root)),
    .angle (pitch_ang)
  );

  // ---------------------------------------------------------------------------
  // Output register: clamp pitch, zero rejected samples
  // ---------------------------------------------------------------------------
  fin_t                      fc;
  logic signed [ANGLE_W-1:0] pv;
  logic                      ok_r;
  logic signed [COMP_W-1:0]  nw_r, nx_r, ny_r, nz_r;
  logic signed [ANGLE_W-1:0] roll_r, yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic [ACC_W-1:0]          acc_r;

  always_comb begin
    fc = sdc_r[CORDIC_LAT-1];
    if (fc.pole_pos) begin
      pv = ANGLE_W'(PITCH_LIM);
    end else if (fc.pole_neg) begin
      pv = -ANGLE_W'(PITCH_LIM);
    end else if (pitch_ang > ANGLE_W'(PITCH_LIM)) begin
      pv = ANGLE_W'(PITCH_LIM);
    end else if (pitch_ang < -ANGLE_W'(PITCH_LIM)) begin
      pv = -ANGLE_W'(PITCH_LIM);
    end else begin
      pv = pitch_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r    <= fc.nq.ok;
      acc_r   <= fc.nq.acc;
      nw_r    <= fc.nq.ok ? fc.nq.w : '0;
      nx_r    <= fc.nq.ok ? fc.nq.x : '0;
      ny_r    <= fc.nq.ok ? fc.nq.y : '0;
      nz_r    <= fc.nq.ok ? fc.nq.z : '0;
      roll_r  <= fc.nq.ok ? roll_ang : '0;
      yaw_r   <= fc.nq.ok ? yaw_ang : '0;
      pitch_r <= fc.nq.ok ? pv[PITCH_W-1:0] : '0;
    end
  end

  assign out_sample_ok = ok_r;
  assign out_norm_w    = nw_r;
  assign out_norm_x    = nx_r;
  assign out_norm_y    = ny_r;
  assign out_norm_z    = nz_r;
  assign out_roll_deg  = roll_r;
  assign out_pitch_deg = pitch_r;
  assign out_yaw_deg   = yaw_r;
  assign out_accuracy  = acc_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match a held output item");

  a_reject_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_ok) |-> (out_norm_w == 0 && out_norm_x == 0 &&
      out_norm_y == 0 && out_norm_z == 0 && out_roll_deg == 0 &&
      out_pitch_deg == 0 && out_yaw_deg == 0))
    else $error("rejected item carries nonzero fields");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_deg <= PITCH_W'(PITCH_LIM) &&
                   out_pitch_deg >= -PITCH_W'(PITCH_LIM)))
    else $error("pitch outside plus or minus ninety degrees");

  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_ok) |-> (out_norm_w <= 16384 && out_norm_w >= -16384))
    else $error("normalized component beyond unit range");

endmodule
